// ===== design/bba_pkg.sv =====
// Shared types, codes and sizing constants for the bitmap block allocator.
// No dependencies; imported by every module of the block except bba_ram.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 65536;
    localparam int WORD_BITS_DEF  = 32;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 17;
    localparam int FREE_W   = 17;
    localparam int CFG_IDX_W = 2;

    // summary row: one "word full" flag per bitmap word
    localparam int SUM_BITS = 64;
    localparam int SUM_LOG  = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'h10000;
    localparam logic [FREE_W-1:0]  FREE_RESET  = 17'h10000;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TEST    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd1;

    typedef logic [SUM_BITS-1:0] t_sum;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] block_index;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0]  result_index;
        logic                bit_value;
        logic [STATUS_W-1:0] status;
    } t_out;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               load_free;
        logic [FREE_W-1:0]  free_value;
    } t_cfg_ctl;

endpackage

// ===== design/bba_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No package dependency.
module bba_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_engine.sv =====
// Allocation engine: bitmap RAM, word-full summary RAM, row-full flags and the
// sequencer that searches, reads, modifies and writes back. Uses bba_pkg, bba_ram.
module bba_engine #(
    parameter int NUM_BLOCKS = 65536,
    parameter int WORD_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bba_pkg::t_in      i_req,
    input  bba_pkg::t_cfg_ctl i_ctl,
    output logic              o_ready,
    output logic              o_done,
    output bba_pkg::t_out     o_res,
    input  logic              i_take
);
    import bba_pkg::*;

    localparam int WBL    = $clog2(WORD_BITS);
    localparam int NWORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int NROWS  = (NWORDS + SUM_BITS - 1) / SUM_BITS;
    localparam int RW     = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int NRP    = 1 << RW;
    localparam int WAW    = RW + SUM_LOG;
    localparam int BW     = WAW + WBL;
    localparam int CW     = ((BW > TOTAL_W) ? BW : TOTAL_W) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_SUMRD = 3'd3;
    localparam logic [2:0] ST_WORD  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_MOD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [WAW-1:0]     r_clr, n_clr;
    logic [NRP-1:0]     r_rowfull, n_rowfull;
    logic [FREE_W-1:0]  r_free, n_free;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic [WAW-1:0]     r_waddr, n_waddr;
    t_out               r_res, n_res;

    logic                 bm_we, bm_re;
    logic [WAW-1:0]       bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
    logic                 sum_we, sum_re;
    logic [RW-1:0]        sum_waddr, sum_raddr;
    t_sum                 sum_wdata, sum_rdata;

    logic [CW-1:0]        eff_total;
    logic [RW-1:0]        free_row;
    logic [SUM_LOG-1:0]   sum_free;
    logic [WBL-1:0]       word_free;
    logic [CW-1:0]        idx_ext;
    logic [WAW-1:0]       idx_word;
    logic [WBL-1:0]       idx_bit;
    logic [BW-1:0]        blk;
    logic [WBL-1:0]       bit_sel;
    logic [WORD_BITS-1:0] word_set, word_clr;
    logic [RW-1:0]        row;
    t_sum                 sum_set, sum_clr;

    bba_ram #(.DATA_W(WORD_BITS), .ADDR_W(WAW)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    bba_ram #(.DATA_W(SUM_BITS), .ADDR_W(RW)) u_summary (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    assign eff_total = (CW'(i_ctl.total) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                            : CW'(i_ctl.total);

    always_comb begin
        free_row = '0;
        for (int i = NRP - 1; i >= 0; i--) begin
            if (!r_rowfull[i]) begin
                free_row = RW'(i);
            end
        end
    end

    always_comb begin
        sum_free = '0;
        for (int i = SUM_BITS - 1; i >= 0; i--) begin
            if (!sum_rdata[i]) begin
                sum_free = SUM_LOG'(i);
            end
        end
    end

    always_comb begin
        word_free = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!bm_rdata[i]) begin
                word_free = WBL'(i);
            end
        end
    end

    assign idx_ext  = CW'(r_idx);
    assign idx_word = idx_ext[WBL +: WAW];
    assign idx_bit  = r_idx[WBL-1:0];
    assign blk      = {r_waddr, word_free};
    assign bit_sel  = (r_func == FUNC_ALLOC) ? word_free : idx_bit;
    assign word_set = bm_rdata | (WORD_BITS'(1) << bit_sel);
    assign word_clr = bm_rdata & ~(WORD_BITS'(1) << bit_sel);
    assign row      = r_waddr[WAW-1:SUM_LOG];
    assign sum_set  = sum_rdata | (t_sum'(1) << r_waddr[SUM_LOG-1:0]);
    assign sum_clr  = sum_rdata & ~(t_sum'(1) << r_waddr[SUM_LOG-1:0]);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_rowfull = r_rowfull;
        n_free    = r_free;
        n_func    = r_func;
        n_idx     = r_idx;
        n_waddr   = r_waddr;
        n_res     = r_res;
        bm_we     = 1'b0;
        bm_waddr  = r_waddr;
        bm_wdata  = word_set;
        bm_re     = 1'b0;
        bm_raddr  = r_waddr;
        sum_we    = 1'b0;
        sum_waddr = row;
        sum_wdata = sum_set;
        sum_re    = 1'b0;
        sum_raddr = row;

        case (r_state)
            ST_CLEAR: begin
                bm_we     = 1'b1;
                bm_waddr  = r_clr;
                bm_wdata  = '0;
                sum_we    = 1'b1;
                sum_waddr = r_clr[RW-1:0];
                sum_wdata = '0;
                n_clr     = r_clr + WAW'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_func  = i_req.func;
                    n_idx   = i_req.block_index;
                    n_state = (i_req.func == FUNC_ALLOC) ? ST_ALLOC : ST_CHECK;
                end
            end
            ST_ALLOC: begin
                if (r_free == '0 || &r_rowfull) begin
                    n_res   = '{result_index: '0, bit_value: 1'b0, status: STATUS_NOFREE};
                    n_state = ST_DONE;
                end else begin
                    sum_re    = 1'b1;
                    sum_raddr = free_row;
                    n_waddr   = {free_row, SUM_LOG'(0)};
                    n_state   = ST_SUMRD;
                end
            end
            ST_SUMRD: begin
                bm_re    = 1'b1;
                bm_raddr = {row, sum_free};
                n_waddr  = {row, sum_free};
                n_state  = ST_WORD;
            end
            ST_WORD: begin
                if (CW'(blk) >= eff_total) begin
                    n_res = '{result_index: '0, bit_value: 1'b0, status: STATUS_NOFREE};
                end else begin
                    bm_we  = 1'b1;
                    n_free = r_free - FREE_W'(1);
                    if (&word_set) begin
                        sum_we = 1'b1;
                        if (&sum_set) begin
                            n_rowfull[row] = 1'b1;
                        end
                    end
                    n_res = '{result_index: INDEX_W'(blk), bit_value: 1'b0,
                              status: STATUS_OK};
                end
                n_state = ST_DONE;
            end
            ST_CHECK: begin
                if (idx_ext >= eff_total) begin
                    n_res   = '{result_index: r_idx, bit_value: 1'b0, status: STATUS_RANGE};
                    n_state = ST_DONE;
                end else begin
                    bm_re     = 1'b1;
                    bm_raddr  = idx_word;
                    sum_re    = 1'b1;
                    sum_raddr = idx_word[WAW-1:SUM_LOG];
                    n_waddr   = idx_word;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                n_res = '{result_index: r_idx, bit_value: 1'b0, status: STATUS_OK};
                case (r_func)
                    FUNC_RELEASE: begin
                        bm_we          = 1'b1;
                        bm_wdata       = word_clr;
                        sum_we         = 1'b1;
                        sum_wdata      = sum_clr;
                        n_rowfull[row] = 1'b0;
                        if (CW'(r_free) < eff_total) begin
                            n_free = r_free + FREE_W'(1);
                        end
                    end
                    FUNC_MARK: begin
                        bm_we = 1'b1;
                        if (&word_set) begin
                            sum_we = 1'b1;
                            if (&sum_set) begin
                                n_rowfull[row] = 1'b1;
                            end
                        end
                    end
                    FUNC_TEST: begin
                        n_res.bit_value = bm_rdata[idx_bit];
                    end
                    default: begin
                    end
                endcase
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_ctl.load_free) begin
            n_free = i_ctl.free_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_rowfull <= '0;
            r_free    <= FREE_RESET;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_rowfull <= n_rowfull;
            r_free    <= n_free;
        end
        r_func  <= n_func;
        r_idx   <= n_idx;
        r_waddr <= n_waddr;
        r_res   <= n_res;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_done  = (r_state == ST_DONE);
    assign o_res   = r_res;

endmodule

// ===== design/bitmap_block_allocator.sv =====
// Bitmap block allocator: top level with configuration registers and output word register.
// Depends on bba_pkg and bba_engine.
//
// One word is worked on at a time. An allocate reads a summary row, then a bitmap word,
// writes the word back and hands the result to the output register; it answers without
// a read when the counter is zero or every summary row is full. Release, mark-used and
// test read the word and its summary row together, then write back (test only reads)
// and hand over; an out-of-range index is answered without a read. The RAM reads are
// registered, and a stalled output word holds the engine until it is taken. Allocation
// is first fit: the lowest non-full summary row is taken from flip-flop flags, the lowest
// non-full word from the summary row, then the lowest clear bit of that word.
// After reset a clearing pass writes every bitmap word (2048 words at the default sizes;
// NUM_BLOCKS/WORD_BITS rounded up to 64 times a power of two, at least 128) with o_stall
// high; configuration writes are taken at any time. WORD_BITS must be a power of two.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  bba_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output bba_pkg::t_out                     o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bba_pkg::TOTAL_W-1:0]       i_cfg_data
);
    import bba_pkg::*;

    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;
    t_out               r_out;
    t_cfg_ctl           ctl;
    logic               cfg_we;
    logic               eng_ready, eng_done, take;
    t_out               eng_res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (cfg_we && i_cfg_index == CFG_TOTAL) begin
            r_total <= i_cfg_data;
        end
    end

    assign ctl.total      = r_total;
    assign ctl.load_free  = cfg_we && (i_cfg_index == CFG_INIT);
    assign ctl.free_value = i_cfg_data;

    bba_engine #(.NUM_BLOCKS(NUM_BLOCKS), .WORD_BITS(WORD_BITS)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_valid && !o_stall),
        .i_req   (i_data),
        .i_ctl   (ctl),
        .o_ready (eng_ready),
        .o_done  (eng_done),
        .o_res   (eng_res),
        .i_take  (take)
    );

    assign o_stall = !eng_ready;
    assign take    = eng_done && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= eng_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== design/bba_checker.sv =====
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg.
module bba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input bba_pkg::t_out                 o_data
);
    import bba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken on two consecutive cycles");

    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == STATUS_NOFREE |->
            o_data.result_index == '0 && !o_data.bit_value)
        else $error("failed allocate carries data");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block not held off after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
